// ===== sv/sprite_table_builder_top_macros.svh =====
// assertion macros for the sprite table builder
// expects clk and rst_n in the scope of use
`ifndef SPRITE_TABLE_BUILDER_TOP_MACROS_SVH
`define SPRITE_TABLE_BUILDER_TOP_MACROS_SVH

// same-cycle implication
`define STB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/stb_pkg.sv =====
// shared types and constants of the sprite table builder
// no dependencies
package stb_pkg;

  localparam int MAX_SPRITES = 64;
  localparam int CNT_W       = $clog2(MAX_SPRITES + 1);
  localparam int IDX_W       = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;

  localparam int COORD_W  = 10;
  localparam int LINK_W   = 7;
  localparam int ATTR_W   = 16;
  localparam int SIZE_W   = 4;
  localparam int POS_W    = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  localparam logic [8:0] RST_SCREEN_WIDTH  = 9'd320;
  localparam logic [8:0] RST_SCREEN_HEIGHT = 9'd240;
  localparam logic [6:0] RST_CULL_MARGIN   = 7'd32;
  localparam logic [7:0] RST_COORD_OFFSET  = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 8'd0,
    REG_SCREEN_HEIGHT = 8'd1,
    REG_CULL_MARGIN   = 8'd2,
    REG_COORD_OFFSET  = 8'd3
  } reg_idx_t;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_FLUSH = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_FULL    = 2'd1,
    ST_CULLED  = 2'd2,
    ST_FLUSHED = 2'd3
  } status_t;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  size;
    logic [LINK_W-1:0]  link;
    logic [ATTR_W-1:0]  attr;
    logic [COORD_W-1:0] x;
  } store_t;

  typedef struct packed {
    status_t status;
    store_t  entry;
    logic    last;
  } out_item_t;

  typedef struct packed {
    logic load_add;
    logic wr_en;
    logic load_empty;
    logic load_entry;
    logic rd_en;
    logic rd_first;
    logic cnt_clr;
  } ctl_cmd_t;

  typedef struct packed {
    logic add_ok;
    logic full;
    logic count_zero;
    logic idx_last;
  } dp_sts_t;

endpackage

// ===== sv/stb_if.sv =====
// channel interfaces: sprite command input, table result output, register writes
// depends on stb_pkg
interface stb_in_if import stb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [ATTR_W-1:0]       attr_word;
  logic [SIZE_W-1:0]       size_code;

  modport source (output valid, command, pos_x, pos_y, attr_word, size_code, input ready);
  modport sink   (input valid, command, pos_x, pos_y, attr_word, size_code, output ready);
endinterface

interface stb_out_if import stb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [COORD_W-1:0] entry_y;
  logic [SIZE_W-1:0]  entry_size;
  logic [LINK_W-1:0]  entry_link;
  logic [ATTR_W-1:0]  entry_attr;
  logic [COORD_W-1:0] entry_x;
  logic               last;

  modport source (output valid, status, entry_y, entry_size, entry_link, entry_attr,
                  entry_x, last, input ready);
  modport sink   (input valid, status, entry_y, entry_size, entry_link, entry_attr,
                  entry_x, last, output ready);
endinterface

interface stb_cfg_if import stb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] addr;
  logic [CFG_DAT_W-1:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

// ===== sv/stb_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module stb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/stb_dp.sv =====
// datapath: config registers, cull and offset logic, sprite count, table ram, result register
// depends on stb_pkg and stb_ram
module stb_dp import stb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctl_cmd_t                cmd,
  output dp_sts_t                 sts,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic [ATTR_W-1:0]       attr_word,
  input  logic [SIZE_W-1:0]       size_code,
  input  logic                    cfg_valid,
  input  logic [CFG_IDX_W-1:0]    cfg_addr,
  input  logic [CFG_DAT_W-1:0]    cfg_wdata,
  output out_item_t               out_item
);

  logic [8:0]       width_r, height_r;
  logic [6:0]       margin_r;
  logic [7:0]       offset_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  out_item_t        out_r, out_nxt;

  logic signed [POS_W:0] x_s, y_s, neg_m, lim_x, lim_y;
  logic                  cull, full, idx_last;
  store_t                add_entry, rd_entry;
  logic [IDX_W-1:0]      rd_addr;

  assign x_s   = {pos_x[POS_W-1], pos_x};
  assign y_s   = {pos_y[POS_W-1], pos_y};
  assign neg_m = -$signed({{(POS_W - 6){1'b0}}, margin_r});
  assign lim_x = $signed({{(POS_W - 8){1'b0}}, width_r});
  assign lim_y = $signed({{(POS_W - 8){1'b0}}, height_r});

  assign cull = (x_s <= neg_m) || (x_s >= lim_x) || (y_s <= neg_m) || (y_s >= lim_y);
  assign full = (count_r >= CNT_W'(MAX_SPRITES));

  assign add_entry.y    = pos_y[COORD_W-1:0] + {{(COORD_W - 8){1'b0}}, offset_r};
  assign add_entry.size = size_code;
  assign add_entry.link = LINK_W'(count_r + CNT_W'(1));
  assign add_entry.attr = attr_word;
  assign add_entry.x    = pos_x[COORD_W-1:0] + {{(COORD_W - 8){1'b0}}, offset_r};

  assign idx_last = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;
  assign rd_addr  = cmd.rd_first ? '0 : IDX_W'(idx_r + IDX_W'(1));

  assign sts.add_ok     = !full && !cull;
  assign sts.full       = full;
  assign sts.count_zero = (count_r == '0);
  assign sts.idx_last   = idx_last;

  stb_ram #(
    .WIDTH($bits(store_t)),
    .DEPTH(MAX_SPRITES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (add_entry),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    out_nxt   = out_r;
    if (cmd.wr_en) begin
      count_nxt = CNT_W'(count_r + CNT_W'(1));
    end
    if (cmd.cnt_clr) begin
      count_nxt = '0;
    end
    if (cmd.rd_en) begin
      idx_nxt = rd_addr;
    end
    if (cmd.load_add) begin
      out_nxt.last = 1'b1;
      if (full) begin
        out_nxt.status = ST_FULL;
        out_nxt.entry  = '0;
      end else if (cull) begin
        out_nxt.status = ST_CULLED;
        out_nxt.entry  = '0;
      end else begin
        out_nxt.status = ST_ADDED;
        out_nxt.entry  = add_entry;
      end
    end else if (cmd.load_empty) begin
      out_nxt.status = ST_FLUSHED;
      out_nxt.entry  = '0;
      out_nxt.last   = 1'b1;
    end else if (cmd.load_entry) begin
      out_nxt.status = ST_FLUSHED;
      out_nxt.entry  = rd_entry;
      out_nxt.last   = idx_last;
      if (idx_last) begin
        out_nxt.entry.link = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_SCREEN_WIDTH;
      height_r <= RST_SCREEN_HEIGHT;
      margin_r <= RST_CULL_MARGIN;
      offset_r <= RST_COORD_OFFSET;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (cfg_valid) begin
        case (cfg_addr)
          REG_SCREEN_WIDTH:  width_r  <= cfg_wdata[8:0];
          REG_SCREEN_HEIGHT: height_r <= cfg_wdata[8:0];
          REG_CULL_MARGIN:   margin_r <= cfg_wdata[6:0];
          REG_COORD_OFFSET:  offset_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  assign out_item = out_r;

endmodule

// ===== sv/stb_ctrl.sv =====
// controller: accepts commands, sequences the flush read stream, owns result valid
// depends on stb_pkg and the assertion macro header
`include "sprite_table_builder_top_macros.svh"
module stb_ctrl import stb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_command,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          if (in_command == CMD_ADD) begin
            cmd.load_add  = 1'b1;
            cmd.wr_en     = sts.add_ok;
            out_valid_nxt = 1'b1;
          end else if (sts.count_zero) begin
            cmd.load_empty = 1'b1;
            out_valid_nxt  = 1'b1;
          end else begin
            cmd.rd_en    = 1'b1;
            cmd.rd_first = 1'b1;
            state_nxt    = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          cmd.load_entry = 1'b1;
          out_valid_nxt  = 1'b1;
          if (sts.idx_last) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            cmd.rd_en = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `STB_ASSERT_SAME(a_no_overwrite, out_valid_r && !out_ready,
                   !(cmd.load_add || cmd.load_empty || cmd.load_entry),
                   "result overwritten while held")
  `STB_ASSERT_SAME(a_no_write_full, cmd.wr_en, !sts.full, "table write while full")
  `STB_ASSERT_SAME(a_flush_nonempty, state_r == S_FLUSH, !sts.count_zero,
                   "flush streaming from empty table")
  `STB_ASSERT_NEXT(a_clear_empties, cmd.cnt_clr, sts.count_zero && state_r == S_IDLE,
                   "table not empty after flush")

endmodule

// ===== sv/sprite_table_builder_top.sv =====
// Sprite table builder. An add command is culled against the screen window widened
// by the margin on its left and top edges only, refused when the table holds
// MAX_SPRITES entries, or stored with offset coordinates, and its single result is
// registered at the output. A flush of n stored entries first makes a registered
// read of the table ram, then sends one entry per cycle from its single read port
// while the output is not held, the last with link zero and last set; an empty
// table flushes one all-zero entry. The table contents are undefined after reset and
// no clearing pass runs. Register writes are always taken and must be made idle.
// depends on stb_pkg, the channel interfaces, stb_ctrl and stb_dp
module sprite_table_builder_top import stb_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  stb_in_if.sink    in_ch,
  stb_out_if.source out_ch,
  stb_cfg_if.sink   cfg_ch
);

  ctl_cmd_t  cmd;
  dp_sts_t   sts;
  out_item_t out_item;

  stb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_command (in_ch.command),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  stb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .pos_x     (in_ch.pos_x),
    .pos_y     (in_ch.pos_y),
    .attr_word (in_ch.attr_word),
    .size_code (in_ch.size_code),
    .cfg_valid (cfg_ch.valid),
    .cfg_addr  (cfg_ch.addr),
    .cfg_wdata (cfg_ch.wdata),
    .out_item  (out_item)
  );

  assign cfg_ch.ready      = 1'b1;
  assign out_ch.status     = out_item.status;
  assign out_ch.entry_y    = out_item.entry.y;
  assign out_ch.entry_size = out_item.entry.size;
  assign out_ch.entry_link = out_item.entry.link;
  assign out_ch.entry_attr = out_item.entry.attr;
  assign out_ch.entry_x    = out_item.entry.x;
  assign out_ch.last       = out_item.last;

endmodule
